// ----- src/mh_sig_pkg.sv -----
// Shared types and constants for the MinHash signature block.
package mh_sig_pkg;

    localparam int NUM_HASHES = 16;
    localparam int IDX_W      = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
    localparam int SLOT_W     = 4;
    localparam int CMP_W      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int HB_W       = 5;

    localparam logic [HB_W-1:0] HASH_BITS_RST = HB_W'(16);
    localparam logic [31:0]     HASH_MAX_POS  = 32'h7FFF_FFFF;
    localparam logic [31:0]     NO_ELEMENT    = 32'hFFFF_FFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ELEM = 1'b1;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [30:0]        coef_a;
        logic [30:0]        coef_b;
        logic signed [31:0] element;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         hash_index;
        logic signed [31:0] min_element;
        logic               last_entry;
    } t_out_item;

    // Token moving down the cell chain.
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_tok;

endpackage

// ----- src/mh_sig_cell.sv -----
// One hash cell: coefficients, running minimum and a two-stage hash datapath.
module mh_sig_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mh_sig_pkg::IDX_W-1:0] i_cell_idx,
    input  logic [mh_sig_pkg::HB_W-1:0]  i_hash_bits,
    input  mh_sig_pkg::t_tok           i_tok,
    output mh_sig_pkg::t_tok           o_tok,
    input  logic                       i_shift,
    input  logic [31:0]                i_res_next,
    output logic [31:0]                o_res
);
    import mh_sig_pkg::*;

    t_tok        r_tok1, r_tok2;
    logic [30:0] r_a, r_b;
    logic [31:0] r_prod;
    logic [31:0] r_best_hash, r_best_elem, r_res;
    logic [31:0] lin, hash;
    logic [5:0]  shamt;
    logic        is_elem, better, slot_hit;
    logic [31:0] n_best_elem;

    assign slot_hit = (CMP_W'(i_cell_idx) == CMP_W'(r_tok1.item.slot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1.valid <= 1'b0;
            r_tok2.valid <= 1'b0;
        end else begin
            r_tok1.valid <= i_tok.valid;
            r_tok2.valid <= r_tok1.valid;
        end
        r_tok1.item <= i_tok.item;
        r_tok2.item <= r_tok1.item;
        r_prod      <= 32'({1'b0, r_a} * r_tok1.item.element);
        // coefficient load lands as the token passes stage 1
        if (r_tok1.valid && r_tok1.item.op == OP_LOAD && slot_hit) begin
            r_a <= r_tok1.item.coef_a;
            r_b <= r_tok1.item.coef_b;
        end
    end

    // stage 2: offset, arithmetic shift, signed compare
    assign lin     = r_prod + {1'b0, r_b};
    assign shamt   = 6'd32 - {1'b0, i_hash_bits};
    assign hash    = 32'($signed({{32{lin[31]}}, lin}) >>> shamt);
    assign is_elem = r_tok2.valid && (r_tok2.item.op == OP_ELEM);
    assign better  = $signed(hash) < $signed(r_best_hash);
    assign n_best_elem = better ? r_tok2.item.element : r_best_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_hash <= HASH_MAX_POS;
            r_best_elem <= NO_ELEMENT;
        end else if (is_elem) begin
            if (r_tok2.item.last) begin
                r_best_hash <= HASH_MAX_POS;
                r_best_elem <= NO_ELEMENT;
            end else if (better) begin
                r_best_hash <= hash;
                r_best_elem <= r_tok2.item.element;
            end
        end
    end

    // result register: captured at end of set, shifted toward cell 0 on unload
    always_ff @(posedge i_clk) begin
        if (is_elem && r_tok2.item.last) begin
            r_res <= n_best_elem;
        end else if (i_shift) begin
            r_res <= i_res_next;
        end
    end

    assign o_tok = r_tok2;
    assign o_res = r_res;

endmodule

// ----- src/minhash_signature_unit.sv -----
// Top level of the MinHash signature block: cell chain, unload control, ports.
// Output: the first signature entry is valid once the set's last element has left the final cell
//   (two register stages per cell), then one entry per output transaction.
// Throughput: one transaction per cycle for loads and non-final elements; input is held off
//   from the last element until the final entry is taken.
// Reset (synchronous, active low): hash_bits = 16, minima cleared, chain empty.
module minhash_signature_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  mh_sig_pkg::t_in_item    i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output mh_sig_pkg::t_out_item   o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [mh_sig_pkg::HB_W-1:0] i_cfg_data
);
    import mh_sig_pkg::*;

    logic [HB_W-1:0]  r_hash_bits;
    logic             r_busy, r_drain;
    logic [IDX_W-1:0] r_cnt;

    t_tok        tok   [NUM_HASHES+1];
    logic [31:0] res   [NUM_HASHES+1];
    logic        in_acc, out_acc, shift, cnt_end, tail_last;

    // Inputs are taken until a set's last element is in; the signature must be
    // unloaded before the next set may start.
    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign tok[0].valid = in_acc;
    assign tok[0].item  = i_in_item;
    assign res[NUM_HASHES] = NO_ELEMENT;

    genvar g;
    generate
        for (g = 0; g < NUM_HASHES; g++) begin : g_cell
            mh_sig_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cell_idx  (IDX_W'(g)),
                .i_hash_bits (r_hash_bits),
                .i_tok       (tok[g]),
                .o_tok       (tok[g+1]),
                .i_shift     (shift),
                .i_res_next  (res[g+1]),
                .o_res       (res[g])
            );
        end
    endgenerate

    // Last element leaving the final cell means every result register is loaded.
    assign tail_last = tok[NUM_HASHES].valid && tok[NUM_HASHES].item.op == OP_ELEM
                       && tok[NUM_HASHES].item.last;

    assign out_acc = o_out_valid && i_out_ready;
    assign shift   = out_acc;
    assign cnt_end = (r_cnt == IDX_W'(NUM_HASHES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_bits <= HASH_BITS_RST;
            r_busy      <= 1'b0;
            r_drain     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_hash_bits <= i_cfg_data;
            end
            if (in_acc && i_in_item.op == OP_ELEM && i_in_item.last) begin
                r_busy <= 1'b1;
            end
            if (tail_last) begin
                r_drain <= 1'b1;
                r_cnt   <= '0;
            end else if (out_acc) begin
                r_cnt <= r_cnt + 1'b1;
                if (cnt_end) begin
                    r_drain <= 1'b0;
                    r_busy  <= 1'b0;
                end
            end
        end
    end

    // Cell 0's result register is the output register; the chain shifts per transaction.
    assign o_out_valid            = r_drain;
    assign o_out_item.hash_index  = 4'(r_cnt);
    assign o_out_item.min_element = res[0];
    assign o_out_item.last_entry  = cnt_end;

endmodule

// ----- verif/minhash_signature_unit_test.sv -----
// Self-checking testbench for the MinHash signature unit: random handshakes, scoreboard check.
module minhash_signature_unit_test;
    import mh_sig_pkg::*;

    // Timing of the run. The chain holds a set's last element in every cell's registers
    // before the first signature entry, so DRAIN_CYCLES, with margin, covers it.
    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 6;
    localparam int          DRAIN_CYCLES = 2 * NUM_HASHES + 8;
    localparam int          LONG_HOLD    = 300;
    localparam int          HOLD_AFTER   = 40;
    localparam int unsigned LIMIT_CYCLES = 200000;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    // ------------------------------------------------------------------
    // Scoreboard: shadow copy of the coefficient tables, the running minima
    // and hash_bits. Every accepted input transaction is folded in; a final
    // element queues one signature entry per hash function.
    // ------------------------------------------------------------------
    class minhash_scoreboard;
        logic [31:0] mult_tab   [NUM_HASHES];
        logic [31:0] offset_tab [NUM_HASHES];
        logic [31:0] best_hash  [NUM_HASHES];
        logic [31:0] best_elem  [NUM_HASHES];
        logic [HB_W-1:0] hash_bits;
        t_out_item   sig_entries[$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < NUM_HASHES; i++) begin
                mult_tab[i]   = '0;
                offset_tab[i] = '0;
            end
            hash_bits  = HASH_BITS_RST;
            mismatches = 0;
            clear_minima();
        endfunction

        function void clear_minima();
            for (int i = 0; i < NUM_HASHES; i++) begin
                best_hash[i] = HASH_MAX_POS;
                best_elem[i] = NO_ELEMENT;
            end
        endfunction

        function void set_hash_bits(logic [HB_W-1:0] v);
            hash_bits = v;
        endfunction

        function int pending();
            return sig_entries.size();
        endfunction

        // Multiply-shift hash: 32-bit wrap, then arithmetic shift by 32 - hash_bits
        // (a shift of 32 leaves only the sign fill).
        function logic [31:0] hash_of(int idx, logic [31:0] x);
            logic [31:0]        lin;
            logic signed [63:0] wide;
            int                 amt;
            lin  = mult_tab[idx] * x + offset_tab[idx];
            wide = {{32{lin[31]}}, lin};
            amt  = 32 - int'(hash_bits);
            wide = wide >>> amt;
            return wide[31:0];
        endfunction

        function void absorb_item(t_in_item it);
            logic [31:0] h;
            t_out_item   e;
            if (it.op == OP_LOAD) begin
                if (int'(it.slot) < NUM_HASHES) begin
                    mult_tab[it.slot]   = {1'b0, it.coef_a};
                    offset_tab[it.slot] = {1'b0, it.coef_b};
                end
                return;
            end
            for (int i = 0; i < NUM_HASHES; i++) begin
                h = hash_of(i, it.element);
                // strict less-than: the earlier element keeps a tie
                if ($signed(h) < $signed(best_hash[i])) begin
                    best_hash[i] = h;
                    best_elem[i] = it.element;
                end
            end
            if (!it.last)
                return;
            for (int i = 0; i < NUM_HASHES; i++) begin
                e.hash_index  = i[3:0];
                e.min_element = best_elem[i];
                e.last_entry  = (i == NUM_HASHES - 1);
                sig_entries.push_back(e);
            end
            clear_minima();
        endfunction

        function void check_entry(t_out_item got);
            t_out_item want;
            if (sig_entries.size() == 0) begin
                $display("%0t: unexpected signature entry %p", $time, got);
                mismatches++;
                return;
            end
            want = sig_entries.pop_front();
            if (got.hash_index !== want.hash_index) begin
                $display("%0t: hash_index expected %0d actual %0d",
                         $time, want.hash_index, got.hash_index);
                mismatches++;
            end
            if (got.min_element !== want.min_element) begin
                $display("%0t: min_element expected %0d actual %0d (hash %0d)",
                         $time, want.min_element, got.min_element, want.hash_index);
                mismatches++;
            end
            if (got.last_entry !== want.last_entry) begin
                $display("%0t: last_entry expected %0b actual %0b (hash %0d)",
                         $time, want.last_entry, got.last_entry, want.hash_index);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its ports
    // ------------------------------------------------------------------
    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in_item        i_in_item;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out_item       o_out_item;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [HB_W-1:0] i_cfg_data;

    minhash_signature_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    minhash_scoreboard sb = new();

    // Per-phase idle knobs: a max of zero gives back-to-back stretches.
    int          tx_max_gap  = 4;
    int          rx_max_wait = 4;
    int unsigned entries_seen = 0;
    bit          long_hold_done = 0;
    int unsigned cycle_count = 0;

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Signature receiver. Runs on its own; ready is dropped for a random
    // count of cycles before each transaction, and once, a while into the
    // run, for a long stretch so the chain backs up into the input.
    // ------------------------------------------------------------------
    initial begin
        int w;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && entries_seen >= HOLD_AFTER) begin
                i_out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1;
            end
            w = (rx_max_wait == 0) ? 0 : $urandom_range(0, rx_max_wait);
            if (w > 0) begin
                i_out_ready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_entry(o_out_item);
            entries_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks start and end on a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(t_in_item it);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.absorb_item(it);
        @(negedge i_clk);
    endtask

    // Don't-care fields are filled with noise so every bit toggles.
    function automatic t_in_item make_element(logic [31:0] x, logic is_last);
        t_in_item it;
        it.op      = OP_ELEM;
        it.slot    = SLOT_W'($urandom_range(0, 15));
        it.coef_a  = 31'($urandom());
        it.coef_b  = 31'($urandom());
        it.element = x;
        it.last    = is_last;
        return it;
    endfunction

    function automatic t_in_item make_load(int slot_n, logic [30:0] a, logic [30:0] b,
                                           logic is_last);
        t_in_item it;
        it.op      = OP_LOAD;
        it.slot    = slot_n[SLOT_W-1:0];
        it.coef_a  = a;
        it.coef_b  = b;
        it.element = $urandom();
        it.last    = is_last;
        return it;
    endfunction

    // Element values: mostly random, some extremes, some from a small pool
    // so that equal hashes (and first-wins ties) show up.
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 7))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            3: return 32'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item random_load();
        logic [30:0] a;
        a = 31'($urandom());
        if ($urandom_range(0, 7) != 0)
            a[0] = 1'b1;   // mostly odd multipliers, some even
        return make_load($urandom_range(0, NUM_HASHES - 1), a, 31'($urandom()),
                         1'($urandom_range(0, 1)));
    endfunction

    // Sender holds off until every queued signature entry has been taken,
    // then lets the chain empty before anything touches the register.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_hash_bits(logic [HB_W-1:0] v);
        i_cfg_data  = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_hash_bits(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random phase made of well-formed sets (always closed by a final element),
    // with stray coefficient reloads mixed in. Occasionally a long set.
    task automatic run_sets(int n_items);
        int count;
        int set_len;
        count = 0;
        while (count < n_items) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                  : $urandom_range(1, 8);
            for (int j = 0; j < set_len; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(random_load());
                    count++;
                end
                send_item(make_element(pick_element(), j == set_len - 1));
                count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [HB_W-1:0] hb_plan [6];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset hash_bits. Every slot is loaded before the
        // first element so no hash ever uses unloaded coefficients.
        send_item(make_load(0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1)); // last on a load
        send_item(make_load(1, 31'h0, 31'h0, 1'b0));                  // zero multiplier
        send_item(make_load(2, 31'h2, 31'($urandom()), 1'b0));        // even multiplier
        for (int s = 3; s < NUM_HASHES; s++)
            send_item(make_load(s, 31'($urandom()) | 31'h1, 31'($urandom()), 1'b0));
        send_item(make_element(INT_MIN, 1'b0));
        send_item(make_element(INT_MAX, 1'b0));
        send_item(make_element(32'h0, 1'b0));
        send_item(make_element(32'hFFFF_FFFF, 1'b1));
        send_item(make_element(32'd123, 1'b0));
        send_item(make_element(-32'sd456, 1'b1));
        send_item(make_element(INT_MAX, 1'b1));                       // single-element set

        // Register settings: the extremes first (including zero, where only the
        // sign survives the shift), then the reset value 16 and two random values.
        hb_plan[0] = 5'd1;
        hb_plan[1] = 5'd31;
        hb_plan[2] = 5'd0;
        hb_plan[3] = 5'd16;
        hb_plan[4] = HB_W'($urandom_range(2, 30));
        hb_plan[5] = HB_W'($urandom_range(2, 30));
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_hash_bits(hb_plan[p]);
            // odd phases run without any idling on either side
            tx_max_gap  = (p % 2 == 1) ? 0 : 4;
            rx_max_wait = (p % 2 == 1) ? 0 : 4;
            run_sets(40);
        end

        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
